[rtl/core/oaht_pkg.sv]
// shared types and codes for the open addressing hash table
// depends on nothing; used by oaht_walk and open_addressing_hash_table_top
package oaht_pkg;

    // request mode codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // field widths
    localparam int KEY_W   = 40;
    localparam int REF_W   = 32;
    localparam int SLOT_W  = 7;
    localparam int COUNT_W = 8;

    // one table entry as held in memory
    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [REF_W-1:0] rec_ref;
    } t_entry;

    // one result item
    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   found_key;
        logic [REF_W-1:0]   found_ref;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] probe_count;
    } t_result;

endpackage

[rtl/core/oaht_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/oaht_walk.sv]
// probe walk sequencer: clearing pass, triangular probe over the slot memory,
// insert write-back and result capture
// depends on oaht_pkg and oaht_ram
module oaht_walk #(
    parameter int TABLE_SLOTS = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  logic                       i_mode,
    input  logic [oaht_pkg::KEY_W-1:0] i_key,
    input  logic [oaht_pkg::REF_W-1:0] i_ref,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output oaht_pkg::t_result          o_res
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = IW + 1;
    localparam int EW = $bits(oaht_pkg::t_entry);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_HOLD
    } t_state;

    t_state                     r_state, n_state;
    logic [IW-1:0]              r_clr, n_clr;
    logic                       r_mode, n_mode;
    logic [oaht_pkg::KEY_W-1:0] r_key, n_key;
    logic [oaht_pkg::REF_W-1:0] r_ref, n_ref;
    logic [IW-1:0]              r_pos, n_pos;
    logic [CW-1:0]              r_cnt, n_cnt;
    oaht_pkg::t_result          r_res, n_res;

    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    oaht_pkg::t_entry           ram_wdata;
    logic [IW-1:0]              ram_raddr;
    logic [EW-1:0]              ram_rdata;
    oaht_pkg::t_entry           rd_entry;
    logic [IW+oaht_pkg::SLOT_W-1:0]  slot_ext;
    logic [CW+oaht_pkg::COUNT_W-1:0] cnt_ext;

    assign rd_entry = oaht_pkg::t_entry'(ram_rdata);
    assign slot_ext = {{oaht_pkg::SLOT_W{1'b0}}, r_pos};
    assign cnt_ext  = {{oaht_pkg::COUNT_W{1'b0}}, r_cnt};

    oaht_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_HOLD);
    assign o_res       = r_res;

    // next state, memory access and result decision
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_mode    = r_mode;
        n_key     = r_key;
        n_ref     = r_ref;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = '0;
        ram_raddr = r_pos + r_cnt[IW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + IW'(1);
                if (r_clr == IW'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = i_key[IW-1:0];
                if (i_req_valid) begin
                    n_mode  = i_mode;
                    n_key   = i_key;
                    n_ref   = i_ref;
                    n_pos   = i_key[IW-1:0];
                    n_cnt   = CW'(1);
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                // next probe read is already issued at pos + count
                n_pos = r_pos + r_cnt[IW-1:0];
                n_cnt = r_cnt + CW'(1);
                n_res.probe_count = cnt_ext[oaht_pkg::COUNT_W-1:0];
                n_res.found_key   = '0;
                n_res.found_ref   = '0;
                n_res.slot        = '0;
                if (!rd_entry.used) begin
                    n_state = S_HOLD;
                    if (r_mode == oaht_pkg::MODE_INSERT) begin
                        ram_we            = 1'b1;
                        ram_wdata.used    = 1'b1;
                        ram_wdata.key     = r_key;
                        ram_wdata.rec_ref = r_ref;
                        n_res.status      = oaht_pkg::ST_INSERTED;
                        n_res.found_key   = r_key;
                        n_res.found_ref   = r_ref;
                        n_res.slot        = slot_ext[oaht_pkg::SLOT_W-1:0];
                    end else begin
                        n_res.status = oaht_pkg::ST_NOT_FOUND;
                    end
                end else if (r_mode == oaht_pkg::MODE_SEARCH && rd_entry.key == r_key) begin
                    n_state         = S_HOLD;
                    n_res.status    = oaht_pkg::ST_FOUND;
                    n_res.found_key = rd_entry.key;
                    n_res.found_ref = rd_entry.rec_ref;
                    n_res.slot      = slot_ext[oaht_pkg::SLOT_W-1:0];
                end else if (r_cnt == CW'(TABLE_SLOTS)) begin
                    n_state      = S_HOLD;
                    n_res.status = (r_mode == oaht_pkg::MODE_INSERT) ?
                                   oaht_pkg::ST_FULL : oaht_pkg::ST_NOT_FOUND;
                end
            end
            S_HOLD: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_mode <= n_mode;
        r_key  <= n_key;
        r_ref  <= n_ref;
        r_pos  <= n_pos;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

endmodule

[rtl/core/open_addressing_hash_table_top.sv]
// open addressing hash table with triangular probing, stream interface
// depends on oaht_pkg and oaht_walk (which holds the slot ram)
//
// channel   direction  tdata                                   tuser
// s_axis    in         key[39:0] record_ref[71:40]             mode
// m_axis    out        found_key[39:0] found_ref[71:40]        status[1:0]
//                      slot[78:72] probe_count[86:79] pad[87]
//
// one slot read per cycle from the single read port of the slot ram sets the
// walk length of an item. after reset a clearing pass over every slot runs
// before the first request is taken. one request is in the walk at a time; an
// output register holds a finished result so the next request can enter while
// it waits.
module open_addressing_hash_table_top #(
    parameter int TABLE_SLOTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // key, record_ref
    input  logic        i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata,   // found_key, found_ref, slot, probe_count, pad
    output logic [1:0]  o_m_axis_tuser    // status
);

    logic              res_valid;
    logic              res_ready;
    oaht_pkg::t_result res;
    logic              r_out_valid;
    oaht_pkg::t_result r_out;

    oaht_walk #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_key       (i_s_axis_tdata[39:0]),
        .i_ref       (i_s_axis_tdata[71:40]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || i_m_axis_tready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {1'b0, r_out.probe_count, r_out.slot,
                              r_out.found_ref, r_out.found_key};

endmodule
